FILE: rtl/bresenham_line_rasterizer_assert.svh
// Assertion macros used by the checker in blr_checker.sv
`ifndef BRESENHAM_LINE_RASTERIZER_ASSERT_SVH
`define BRESENHAM_LINE_RASTERIZER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted
`define BLR_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("blr assertion failed");

// Next-cycle implication, disabled while reset is asserted
`define BLR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("blr assertion failed");

`endif

FILE: rtl/blr_pkg.sv
package blr_pkg;

    // default coordinate width
    localparam int CoordBits = 6;

    // most pixels emitted for one segment
    localparam int MaxRes = 64;

    // job queue depth between front and walker
    localparam int JobQueueDepth = 2;

    // reset value of the drawing color
    localparam logic [23:0] ColorReset = 24'h9EE2B2;

    // walker states
    typedef enum logic [0:0] {
        WALK_IDLE,
        WALK_RUN
    } walk_state_t;

endpackage

FILE: rtl/blr_fifo.sv
module blr_fifo import blr_pkg::*; #(
    parameter int WIDTH = 8,
    parameter int DEPTH = JobQueueDepth
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic             not_empty,
    output logic [WIDTH-1:0] pop_data
);

    localparam int PtrW = $clog2(DEPTH);
    localparam int CntW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] entry_reg [DEPTH];
    logic [PtrW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0]  count_reg, count_next;

    assign full      = (count_reg == CntW'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_data  = entry_reg[rd_ptr_reg];

    // pointer and fill count update
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage, no reset
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

FILE: rtl/blr_front.sv
module blr_front import blr_pkg::*; #(
    parameter int COORD_BITS = CoordBits
) (
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [COORD_BITS-1:0] s_start_x,
    input  logic [COORD_BITS-1:0] s_start_y,
    input  logic [COORD_BITS-1:0] s_end_x,
    input  logic [COORD_BITS-1:0] s_end_y,
    input  logic                  queue_full,
    output logic                  queue_push,
    output logic [6*COORD_BITS+2:0] queue_data
);

    typedef struct packed {
        logic [COORD_BITS-1:0] x0;
        logic [COORD_BITS-1:0] y0;
        logic [COORD_BITS-1:0] x1;
        logic [COORD_BITS-1:0] y1;
        logic [COORD_BITS-1:0] dx;
        logic [COORD_BITS-1:0] dy;
        logic                  sx_neg;
        logic                  sy_neg;
        logic                  empty;
    } job_t;

    job_t job;

    assign s_ready    = !queue_full;
    assign queue_push = s_valid && !queue_full;
    assign queue_data = job;

    // absolute deltas, step directions and zero-length detect
    always_comb begin
        job.x0     = s_start_x;
        job.y0     = s_start_y;
        job.x1     = s_end_x;
        job.y1     = s_end_y;
        job.dx     = (s_end_x > s_start_x) ? s_end_x - s_start_x : s_start_x - s_end_x;
        job.dy     = (s_end_y > s_start_y) ? s_end_y - s_start_y : s_start_y - s_end_y;
        job.sx_neg = !(s_start_x < s_end_x);
        job.sy_neg = !(s_start_y < s_end_y);
        job.empty  = (s_start_x == s_end_x) && (s_start_y == s_end_y);
    end

endmodule

FILE: rtl/blr_walk.sv
module blr_walk import blr_pkg::*; #(
    parameter int COORD_BITS = CoordBits
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    job_valid,
    input  logic [6*COORD_BITS+2:0] job_data,
    output logic                    job_pop,
    input  logic [23:0]             draw_color,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic [COORD_BITS-1:0]   m_pixel_x,
    output logic [COORD_BITS-1:0]   m_pixel_y,
    output logic [23:0]             m_pixel_color,
    output logic                    m_empty_res,
    output logic                    m_last
);

    localparam int ErrW = COORD_BITS + 2;
    localparam int CntW = $clog2(MaxRes);

    typedef struct packed {
        logic [COORD_BITS-1:0] x0;
        logic [COORD_BITS-1:0] y0;
        logic [COORD_BITS-1:0] x1;
        logic [COORD_BITS-1:0] y1;
        logic [COORD_BITS-1:0] dx;
        logic [COORD_BITS-1:0] dy;
        logic                  sx_neg;
        logic                  sy_neg;
        logic                  empty;
    } job_t;

    job_t job;
    assign job = job_data;

    walk_state_t state_reg, state_next;

    logic [COORD_BITS-1:0] cur_x_reg, cur_x_next;
    logic [COORD_BITS-1:0] cur_y_reg, cur_y_next;
    logic [COORD_BITS-1:0] end_x_reg, end_y_reg;
    logic [COORD_BITS-1:0] dx_reg, dy_reg;
    logic                  sx_neg_reg, sy_neg_reg;
    logic signed [ErrW-1:0] err_reg, err_next;
    logic [CntW-1:0]       cnt_reg, cnt_next;

    logic                  m_valid_reg, m_valid_next;
    logic [COORD_BITS-1:0] px_reg, px_next;
    logic [COORD_BITS-1:0] py_reg, py_next;
    logic [23:0]           color_reg, color_next;
    logic                  empty_reg, empty_next;
    logic                  last_reg, last_next;

    logic                  out_free;
    logic                  load_job;
    logic                  emit_pixel;
    logic                  step_x, step_y;
    logic                  pixel_last;
    logic signed [ErrW:0]  e2;

    assign out_free = !m_valid_reg || m_ready;

    // step decision on the doubled error term
    always_comb begin
        e2         = {err_reg, 1'b0};
        step_x     = e2 > -$signed({3'b000, dy_reg});
        step_y     = e2 < $signed({3'b000, dx_reg});
        err_next   = err_reg
                   - (step_x ? $signed({2'b00, dy_reg}) : '0)
                   + (step_y ? $signed({2'b00, dx_reg}) : '0);
        cur_x_next = cur_x_reg;
        cur_y_next = cur_y_reg;
        if (step_x) begin
            cur_x_next = sx_neg_reg ? cur_x_reg - 1'b1 : cur_x_reg + 1'b1;
        end
        if (step_y) begin
            cur_y_next = sy_neg_reg ? cur_y_reg - 1'b1 : cur_y_reg + 1'b1;
        end
        cnt_next   = cnt_reg + 1'b1;
        pixel_last = ((cur_x_next == end_x_reg) && (cur_y_next == end_y_reg))
                   || (cnt_reg == CntW'(MaxRes - 1));
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            WALK_IDLE: begin
                if (job_valid && !job.empty) begin
                    state_next = WALK_RUN;
                end
            end
            WALK_RUN: begin
                if (out_free && pixel_last) begin
                    state_next = WALK_IDLE;
                end
            end
            default: state_next = WALK_IDLE;
        endcase
    end

    // control and result register
    always_comb begin
        job_pop      = 1'b0;
        load_job     = 1'b0;
        emit_pixel   = 1'b0;
        m_valid_next = m_valid_reg && !m_ready;
        px_next      = px_reg;
        py_next      = py_reg;
        color_next   = color_reg;
        empty_next   = empty_reg;
        last_next    = last_reg;
        unique case (state_reg)
            WALK_IDLE: begin
                if (job_valid && job.empty) begin
                    // zero-length segment: one marked result, fields cleared
                    if (out_free) begin
                        job_pop      = 1'b1;
                        m_valid_next = 1'b1;
                        px_next      = '0;
                        py_next      = '0;
                        color_next   = '0;
                        empty_next   = 1'b1;
                        last_next    = 1'b1;
                    end
                end else if (job_valid) begin
                    job_pop  = 1'b1;
                    load_job = 1'b1;
                end
            end
            WALK_RUN: begin
                if (out_free) begin
                    emit_pixel   = 1'b1;
                    m_valid_next = 1'b1;
                    px_next      = cur_x_reg;
                    py_next      = cur_y_reg;
                    color_next   = draw_color;
                    empty_next   = 1'b0;
                    last_next    = pixel_last;
                end
            end
            default: ;
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= WALK_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // walk datapath and result payload
    always_ff @(posedge aclk) begin
        px_reg    <= px_next;
        py_reg    <= py_next;
        color_reg <= color_next;
        empty_reg <= empty_next;
        last_reg  <= last_next;
        if (load_job) begin
            cur_x_reg  <= job.x0;
            cur_y_reg  <= job.y0;
            end_x_reg  <= job.x1;
            end_y_reg  <= job.y1;
            dx_reg     <= job.dx;
            dy_reg     <= job.dy;
            sx_neg_reg <= job.sx_neg;
            sy_neg_reg <= job.sy_neg;
            err_reg    <= $signed({2'b00, job.dx}) - $signed({2'b00, job.dy});
            cnt_reg    <= '0;
        end else if (emit_pixel) begin
            cur_x_reg <= cur_x_next;
            cur_y_reg <= cur_y_next;
            err_reg   <= err_next;
            cnt_reg   <= cnt_next;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_pixel_x     = px_reg;
    assign m_pixel_y     = py_reg;
    assign m_pixel_color = color_reg;
    assign m_empty_res   = empty_reg;
    assign m_last        = last_reg;

endmodule

FILE: rtl/bresenham_line_rasterizer.sv
// Channel  | Direction | Handshake           | Payload
// s_       | in        | s_valid / s_ready   | start_x, start_y, end_x, end_y
// m_       | out       | m_valid / m_ready   | pixel_x, pixel_y, pixel_color, empty_res, last
// cfg_     | in        | cfg_wr_en           | draw_color (24 bits)
//
// A segment of N pixels (N = max(|dx|, |dy|), capped at 64) is walked by loading
// the job and then emitting its pixels one by one; a zero-length segment yields one
// marked result. The walker has a single step unit. Segments are accepted while
// the two-entry job queue has room, so the next one is taken during a walk.
// Output stalls hold the walker in place. Synchronous reset (aresetn low) empties
// the queue, idles the walker and sets draw_color to 0x9EE2B2.
module bresenham_line_rasterizer import blr_pkg::*; #(
    parameter int COORD_BITS = CoordBits
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [23:0]           cfg_wr_data,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [COORD_BITS-1:0] s_start_x,
    input  logic [COORD_BITS-1:0] s_start_y,
    input  logic [COORD_BITS-1:0] s_end_x,
    input  logic [COORD_BITS-1:0] s_end_y,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [COORD_BITS-1:0] m_pixel_x,
    output logic [COORD_BITS-1:0] m_pixel_y,
    output logic [23:0]           m_pixel_color,
    output logic                  m_empty_res,
    output logic                  m_last
);

    localparam int JobW = 6 * COORD_BITS + 3;

    logic [23:0]     draw_color_reg;
    logic            queue_full, queue_push, queue_pop, queue_valid;
    logic [JobW-1:0] push_job, pop_job;

    // drawing color register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            draw_color_reg <= ColorReset;
        end else if (cfg_wr_en) begin
            draw_color_reg <= cfg_wr_data;
        end
    end

    blr_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_start_x  (s_start_x),
        .s_start_y  (s_start_y),
        .s_end_x    (s_end_x),
        .s_end_y    (s_end_y),
        .queue_full (queue_full),
        .queue_push (queue_push),
        .queue_data (push_job)
    );

    blr_fifo #(
        .WIDTH (JobW),
        .DEPTH (JobQueueDepth)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (queue_push),
        .push_data (push_job),
        .full      (queue_full),
        .pop       (queue_pop),
        .not_empty (queue_valid),
        .pop_data  (pop_job)
    );

    blr_walk #(
        .COORD_BITS (COORD_BITS)
    ) u_walk (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .job_valid     (queue_valid),
        .job_data      (pop_job),
        .job_pop       (queue_pop),
        .draw_color    (draw_color_reg),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_pixel_x     (m_pixel_x),
        .m_pixel_y     (m_pixel_y),
        .m_pixel_color (m_pixel_color),
        .m_empty_res   (m_empty_res),
        .m_last        (m_last)
    );

endmodule

FILE: rtl/blr_checker.sv
`include "bresenham_line_rasterizer_assert.svh"

module blr_checker import blr_pkg::*; #(
    parameter int COORD_BITS = CoordBits
) (
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  m_valid,
    input logic                  m_ready,
    input logic [COORD_BITS-1:0] m_pixel_x,
    input logic [COORD_BITS-1:0] m_pixel_y,
    input logic [23:0]           m_pixel_color,
    input logic                  m_empty_res,
    input logic                  m_last
);

    logic stalled;
    logic empty_marker;
    logic fields_clear;

    assign stalled      = m_valid && !m_ready;
    assign empty_marker = m_valid && m_empty_res;
    assign fields_clear = (m_pixel_x == '0) && (m_pixel_y == '0) && (m_pixel_color == '0);

    // a stalled result stays offered
    `BLR_ASSERT_NEXT(a_hold_valid, aclk, aresetn, stalled, m_valid)

    // a stalled result keeps its coordinates
    `BLR_ASSERT_NEXT(a_hold_xy, aclk, aresetn, stalled, $stable({m_pixel_x, m_pixel_y}))

    // an empty marker always closes its segment
    `BLR_ASSERT_IMPL(a_empty_last, aclk, aresetn, empty_marker, m_last)

    // an empty marker carries cleared fields
    `BLR_ASSERT_IMPL(a_empty_zero, aclk, aresetn, empty_marker, fields_clear)

endmodule

bind bresenham_line_rasterizer blr_checker #(
    .COORD_BITS (COORD_BITS)
) u_blr_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_pixel_x     (m_pixel_x),
    .m_pixel_y     (m_pixel_y),
    .m_pixel_color (m_pixel_color),
    .m_empty_res   (m_empty_res),
    .m_last        (m_last)
);

FILE: verif/blr_pixel_checker.sv
`timescale 1ns / 1ps

// Scoreboard for the line rasterizer. It predicts the pixel run of every
// segment transfer and checks each pixel transfer against the oldest
// prediction, field by field.
module blr_pixel_checker import blr_pkg::*; #(
    parameter int COORD_BITS = CoordBits
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [23:0]           cfg_wr_data,
    input  logic                  s_valid,
    input  logic                  s_ready,
    input  logic [COORD_BITS-1:0] s_start_x,
    input  logic [COORD_BITS-1:0] s_start_y,
    input  logic [COORD_BITS-1:0] s_end_x,
    input  logic [COORD_BITS-1:0] s_end_y,
    input  logic                  m_valid,
    input  logic                  m_ready,
    input  logic [COORD_BITS-1:0] m_pixel_x,
    input  logic [COORD_BITS-1:0] m_pixel_y,
    input  logic [23:0]           m_pixel_color,
    input  logic                  m_empty_res,
    input  logic                  m_last,
    output int                    mismatch_count,
    output int                    pixels_owed
);

    typedef struct packed {
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
        logic [23:0]           color;
        logic                  empty;
        logic                  last;
    } pixel_t;

    pixel_t      owed_pixels[$];
    logic [23:0] color_shadow;

    // Walk one segment with the doubled error term; the end point is not plotted
    function automatic void predict_segment(input int x0, input int y0,
                                            input int x1, input int y1);
        int     dx, dy, sx, sy, err, e2, x, y, n;
        pixel_t px;
        dx = (x1 > x0) ? x1 - x0 : x0 - x1;
        dy = (y1 > y0) ? y1 - y0 : y0 - y1;
        sx = (x0 < x1) ? 1 : -1;
        sy = (y0 < y1) ? 1 : -1;

        // zero-length segment: a single empty marker with all fields cleared
        if (dx == 0 && dy == 0) begin
            px       = '0;
            px.empty = 1'b1;
            px.last  = 1'b1;
            owed_pixels.push_back(px);
            return;
        end

        err = dx - dy;
        x   = x0;
        y   = y0;
        n   = 0;
        while ((x != x1 || y != y1) && n < MaxRes) begin
            e2       = 2 * err;
            px.x     = x[COORD_BITS-1:0];
            px.y     = y[COORD_BITS-1:0];
            px.color = color_shadow;
            px.empty = 1'b0;
            n++;
            if (e2 > -dy) begin
                err -= dy;
                x   += sx;
            end
            if (e2 < dx) begin
                err += dx;
                y   += sy;
            end
            // last pixel: next step reaches the end point, or the cap is hit
            px.last = ((x == x1 && y == y1) || n == MaxRes);
            owed_pixels.push_back(px);
        end
    endfunction

    task automatic check_field(input string field, input logic [23:0] want,
                               input logic [23:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
            mismatch_count++;
        end
    endtask

    // Sample both channels at the rising edge
    always @(posedge aclk) begin : score
        pixel_t want;
        if (!aresetn) begin
            color_shadow   = ColorReset;
            mismatch_count = 0;
            owed_pixels.delete();
        end else begin
            if (cfg_wr_en)
                color_shadow = cfg_wr_data;

            // pixel transfer: compare with the oldest prediction
            if (m_valid && m_ready) begin
                if (owed_pixels.size() == 0) begin
                    $error("unexpected pixel transfer: x=%0d y=%0d empty=%0b",
                           m_pixel_x, m_pixel_y, m_empty_res);
                    mismatch_count++;
                end else begin
                    want = owed_pixels.pop_front();
                    check_field("pixel_x", 24'(want.x), 24'(m_pixel_x));
                    check_field("pixel_y", 24'(want.y), 24'(m_pixel_y));
                    check_field("pixel_color", want.color, m_pixel_color);
                    check_field("empty_res", 24'(want.empty), 24'(m_empty_res));
                    check_field("last", 24'(want.last), 24'(m_last));
                end
            end

            // segment transfer: queue up its pixel run
            if (s_valid && s_ready)
                predict_segment(int'(s_start_x), int'(s_start_y),
                                int'(s_end_x), int'(s_end_y));
        end
        pixels_owed = owed_pixels.size();
    end

endmodule

FILE: verif/bresenham_line_rasterizer_tb.sv
`timescale 1ns / 1ps

module bresenham_line_rasterizer_tb;
    import blr_pkg::*;

    localparam int CoordMax    = (1 << CoordBits) - 1;
    localparam int HoldCycles  = 300;   // long output hold-off
    localparam int StallLimit  = 2000;  // cycles with no transfer at all
    localparam int SettleCycles = 8;
    localparam int TailCycles  = 80;    // longest walk plus margin
    localparam int PhaseItems  = 22;

    logic                 aclk;
    logic                 aresetn;
    logic                 cfg_wr_en;
    logic [23:0]          cfg_wr_data;
    logic                 s_valid;
    logic                 s_ready;
    logic [CoordBits-1:0] s_start_x;
    logic [CoordBits-1:0] s_start_y;
    logic [CoordBits-1:0] s_end_x;
    logic [CoordBits-1:0] s_end_y;
    logic                 m_valid;
    logic                 m_ready;
    logic [CoordBits-1:0] m_pixel_x;
    logic [CoordBits-1:0] m_pixel_y;
    logic [23:0]          m_pixel_color;
    logic                 m_empty_res;
    logic                 m_last;

    int   mismatch_count;
    int   pixels_owed;
    logic hold_request;
    logic tight_phase;

    // start/end points: zero length, full-span lines, all octants, unit steps
    int directed_segments[23][4] = '{
        '{0, 0, 0, 0}, '{63, 63, 63, 63},
        '{0, 0, 63, 0}, '{63, 5, 0, 5}, '{7, 0, 7, 63}, '{9, 63, 9, 0},
        '{0, 0, 63, 63}, '{63, 63, 0, 0}, '{63, 0, 0, 63}, '{0, 63, 63, 0},
        '{10, 10, 30, 17}, '{10, 10, 17, 30}, '{40, 10, 20, 17}, '{40, 10, 33, 30},
        '{40, 40, 20, 33}, '{40, 40, 33, 20}, '{10, 40, 30, 33}, '{10, 40, 17, 20},
        '{20, 20, 21, 20}, '{20, 20, 21, 21}, '{5, 5, 6, 60},
        '{0, 63, 63, 62}, '{63, 0, 62, 63}
    };

    bresenham_line_rasterizer #(
        .COORD_BITS(CoordBits)
    ) dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_start_x    (s_start_x),
        .s_start_y    (s_start_y),
        .s_end_x      (s_end_x),
        .s_end_y      (s_end_y),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_pixel_x    (m_pixel_x),
        .m_pixel_y    (m_pixel_y),
        .m_pixel_color(m_pixel_color),
        .m_empty_res  (m_empty_res),
        .m_last       (m_last)
    );

    blr_pixel_checker #(
        .COORD_BITS(CoordBits)
    ) u_pixel_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_start_x     (s_start_x),
        .s_start_y     (s_start_y),
        .s_end_x       (s_end_x),
        .s_end_y       (s_end_y),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_pixel_x     (m_pixel_x),
        .m_pixel_y     (m_pixel_y),
        .m_pixel_color (m_pixel_color),
        .m_empty_res   (m_empty_res),
        .m_last        (m_last),
        .mismatch_count(mismatch_count),
        .pixels_owed   (pixels_owed)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // Pixel sink: random ready, open stretches, long stalls, one long hold-off
    initial begin : pixel_sink
        int   left;
        int   choice;
        logic level;
        logic hold_taken;
        left       = 0;
        level      = 1'b0;
        hold_taken = 1'b0;
        m_ready    = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_request && !hold_taken) begin
                hold_taken = 1'b1;
                level      = 1'b0;
                left       = HoldCycles;
            end else if (left == 0) begin
                choice = $urandom_range(0, 99);
                if (choice < 10) begin
                    level = 1'b1;
                    left  = $urandom_range(20, 80);
                end else if (choice < 14) begin
                    level = 1'b0;
                    left  = $urandom_range(15, 50);
                end else begin
                    level = (choice < 75);
                    left  = 1;
                end
            end
            m_ready <= level;
            left--;
        end
    end

    // Watchdog: give up after too long without any transfer
    initial begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < StallLimit) begin
            @(posedge aclk);
            if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Mostly back-to-back or short gaps, now and then a long one
    function automatic int sender_gap();
        int r;
        r = $urandom_range(0, 99);
        if (tight_phase || r < 45)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic int clamp_coord(input int c);
        if (c < 0)
            return 0;
        if (c > CoordMax)
            return CoordMax;
        return c;
    endfunction

    function automatic int edge_coord(input int c);
        case ($urandom_range(0, 2))
            0: return 0;
            1: return CoordMax;
            default: return c;
        endcase
    endfunction

    // Offer one segment after an idle gap and hold it until the transfer
    task automatic send_segment(input int x0, input int y0, input int x1,
                                input int y1, input int gap);
        if (gap > 0) begin
            @(negedge aclk);
            s_valid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_valid   <= 1'b1;
        s_start_x <= x0[CoordBits-1:0];
        s_start_y <= y0[CoordBits-1:0];
        s_end_x   <= x1[CoordBits-1:0];
        s_end_y   <= y1[CoordBits-1:0];
        do @(posedge aclk); while (!s_ready);
    endtask

    // Random segment: zero length, short, edge-hugging or fully random
    task automatic random_segment();
        int x0, y0, x1, y1, kind;
        kind = $urandom_range(0, 99);
        x0   = $urandom_range(0, CoordMax);
        y0   = $urandom_range(0, CoordMax);
        x1   = $urandom_range(0, CoordMax);
        y1   = $urandom_range(0, CoordMax);
        if (kind < 8) begin
            x1 = x0;
            y1 = y0;
        end else if (kind < 30) begin
            x1 = clamp_coord(x0 + int'($urandom_range(0, 8)) - 4);
            y1 = clamp_coord(y0 + int'($urandom_range(0, 8)) - 4);
        end else if (kind < 42) begin
            x0 = edge_coord(x0);
            y0 = edge_coord(y0);
            x1 = edge_coord(x1);
            y1 = edge_coord(y1);
        end
        send_segment(x0, y0, x1, y1, sender_gap());
    endtask

    // Wait for every predicted pixel, then let the walker settle
    task automatic drain_pixels();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pixels_owed != 0) @(negedge aclk);
        repeat (SettleCycles) @(negedge aclk);
    endtask

    task automatic write_color(input logic [23:0] color);
        @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= color;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    // Stimulus: directed segments at the reset color, then random phases
    initial begin : stimulus
        aresetn      = 1'b0;
        cfg_wr_en    = 1'b0;
        cfg_wr_data  = '0;
        s_valid      = 1'b0;
        s_start_x    = '0;
        s_start_y    = '0;
        s_end_x      = '0;
        s_end_y      = '0;
        hold_request = 1'b0;
        tight_phase  = 1'b0;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        for (int i = 0; i < 23; i++)
            send_segment(directed_segments[i][0], directed_segments[i][1],
                         directed_segments[i][2], directed_segments[i][3],
                         sender_gap());

        for (int p = 0; p < 4; p++) begin
            drain_pixels();
            case (p)
                0: write_color(24'h000000);
                1: write_color(24'hFFFFFF);
                default: write_color(24'($urandom));
            endcase
            tight_phase = (p == 1);
            // first phase: sink holds off while segments keep coming
            if (p == 0)
                hold_request = 1'b1;
            for (int i = 0; i < PhaseItems; i++)
                random_segment();
        end

        drain_pixels();
        repeat (TailCycles) @(negedge aclk);
        if (mismatch_count == 0 && pixels_owed == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
